// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL that carries concurrent checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tdc_pkg.sv -----
// ---------------------------------------------------------------------------
// tdc_pkg
// Types and constants for the 24-hour time-of-day seconds counter.
// ---------------------------------------------------------------------------
package tdc_pkg;

    localparam int DAY_SECONDS    = 86400;
    localparam int HOUR_SECONDS   = 3600;
    localparam int MINUTE_SECONDS = 60;
    localparam int HOURS_PER_DAY  = 24;
    localparam int MAX_HOUR       = 23;
    localparam int MAX_MINUTE     = 59;

    // amount mod 86400 is done as (amount >> 7) mod 675, low 7 bits kept
    localparam int LO_BITS     = 7;
    localparam int DAY_HI_DIV  = DAY_SECONDS / (2 ** LO_BITS);

    // exact reciprocal constants: floor(x / D) == (x * RECIP) >> SHIFT
    localparam logic [24:0] RECIP_DAY_HI  = 25'd25451659;  // /675, x < 2^24
    localparam int          SHIFT_DAY_HI  = 34;
    localparam logic [17:0] RECIP_HOUR    = 18'd149131;    // /3600, x < 2^17
    localparam int          SHIFT_HOUR    = 29;
    localparam logic [12:0] RECIP_MINUTE  = 13'd4370;      // /60, x < 2^12
    localparam int          SHIFT_MINUTE  = 18;

    // front pipe depth, fixed by the split datapath
    localparam int FRONT_STAGES = 5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ACT_TICK_UP   = 3'd0,
        ACT_TICK_DOWN = 3'd1,
        ACT_ADD       = 3'd2,
        ACT_SET_HOUR  = 3'd3,
        ACT_SET_MIN   = 3'd4,
        ACT_SET_SEC   = 3'd5,
        ACT_LOAD_HMS  = 3'd6,
        ACT_LOAD_SEC  = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        OP_KEEP,
        OP_ADD,
        OP_SET_H,
        OP_SET_M,
        OP_SET_S,
        OP_LOAD
    } op_t;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] amount;
        logic signed [7:0]  hour_value;
        logic signed [7:0]  minute_value;
        logic signed [7:0]  second_value;
    } in_item_t;

    typedef struct packed {
        logic [4:0] hour_now;
        logic [5:0] minute_now;
        logic [5:0] second_now;
        logic       rejected;
    } out_item_t;

    // decoded command between front and back
    typedef struct packed {
        op_t        op;
        logic       rejected;
        logic [4:0] hh;
        logic [5:0] mm;
        logic [5:0] ss;
    } cmd_t;

    typedef struct packed {
        logic                   full;
        logic                   empty;
        logic [QUEUE_CNT_W-1:0] count;
    } q_stat_t;

endpackage

// ----- rtl/core/tdc_front.sv -----
// ---------------------------------------------------------------------------
// tdc_front
// Decodes actions and splits second counts into h:m:s with a 5-stage pipe.
// ---------------------------------------------------------------------------
module tdc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  tdc_pkg::in_item_t request,
    output logic              cmd_valid,
    output tdc_pkg::cmd_t     cmd,
    input  logic              q_full
);

    typedef struct packed {
        tdc_pkg::op_t op;
        logic         rejected;
        logic         use_div;
        logic [4:0]   hh;
        logic [5:0]   mm;
        logic [5:0]   ss;
    } fe_cmd_t;

    logic                  adv;
    logic [tdc_pkg::FRONT_STAGES-1:0] vld_reg;
    logic [tdc_pkg::FRONT_STAGES-1:0] vld_next;
    fe_cmd_t               pipe_reg [tdc_pkg::FRONT_STAGES];
    fe_cmd_t               dec_next;

    logic                  pos_amt;
    logic                  h_ok;
    logic                  m_ok;
    logic                  s_ok;

    logic [23:0]           hi_next;
    logic [23:0]           hi_reg;
    logic [48:0]           p1_next;
    logic [48:0]           p1_reg;
    logic [tdc_pkg::LO_BITS-1:0] lo1_reg;

    logic [14:0]           q1;
    logic [23:0]           r1;
    logic [16:0]           t2_next;
    logic [16:0]           t2_reg;

    logic [34:0]           p3_next;
    logic [34:0]           p3_reg;
    logic [16:0]           t3_reg;

    logic [4:0]            h4_next;
    logic [16:0]           rem4_full;
    logic [11:0]           rem4_next;
    logic [4:0]            h4_reg;
    logic [11:0]           rem4_reg;

    logic [24:0]           p5_next;
    logic [24:0]           p5_reg;
    logic [11:0]           rem5_reg;
    logic [4:0]            h5_reg;

    logic [5:0]            m_fin;
    logic [11:0]           s_full;

    // whole pipe holds while the last stage waits on a full queue
    assign adv  = !(vld_reg[tdc_pkg::FRONT_STAGES-1] && q_full);
    assign full = !adv;

    // ---- decode ----
    assign pos_amt = !request.amount[31] && (request.amount != 32'sd0);
    assign h_ok = !request.hour_value[7]
                  && (request.hour_value[6:0] <= 7'(tdc_pkg::MAX_HOUR));
    assign m_ok = !request.minute_value[7]
                  && (request.minute_value[6:0] <= 7'(tdc_pkg::MAX_MINUTE));
    assign s_ok = !request.second_value[7]
                  && (request.second_value[6:0] <= 7'(tdc_pkg::MAX_MINUTE));

    always_comb
    begin
        dec_next          = '0;
        dec_next.op       = tdc_pkg::OP_KEEP;
        case (tdc_pkg::action_t'(request.action))
            tdc_pkg::ACT_TICK_UP:
            begin
                dec_next.op = tdc_pkg::OP_ADD;
                dec_next.ss = 6'd1;
            end
            tdc_pkg::ACT_TICK_DOWN:
            begin
                // minus one second == plus 23:59:59
                dec_next.op = tdc_pkg::OP_ADD;
                dec_next.hh = 5'(tdc_pkg::MAX_HOUR);
                dec_next.mm = 6'(tdc_pkg::MAX_MINUTE);
                dec_next.ss = 6'(tdc_pkg::MAX_MINUTE);
            end
            tdc_pkg::ACT_ADD:
            begin
                if (pos_amt)
                begin
                    dec_next.op      = tdc_pkg::OP_ADD;
                    dec_next.use_div = 1'b1;
                end
                else
                begin
                    dec_next.rejected = 1'b1;
                end
            end
            tdc_pkg::ACT_SET_HOUR:
            begin
                if (h_ok)
                begin
                    dec_next.op = tdc_pkg::OP_SET_H;
                    dec_next.hh = request.hour_value[4:0];
                end
                else
                begin
                    dec_next.rejected = 1'b1;
                end
            end
            tdc_pkg::ACT_SET_MIN:
            begin
                if (m_ok)
                begin
                    dec_next.op = tdc_pkg::OP_SET_M;
                    dec_next.mm = request.minute_value[5:0];
                end
                else
                begin
                    dec_next.rejected = 1'b1;
                end
            end
            tdc_pkg::ACT_SET_SEC:
            begin
                if (s_ok)
                begin
                    dec_next.op = tdc_pkg::OP_SET_S;
                    dec_next.ss = request.second_value[5:0];
                end
                else
                begin
                    dec_next.rejected = 1'b1;
                end
            end
            tdc_pkg::ACT_LOAD_HMS:
            begin
                dec_next.op = tdc_pkg::OP_LOAD;
                if (h_ok && m_ok && s_ok)
                begin
                    dec_next.hh = request.hour_value[4:0];
                    dec_next.mm = request.minute_value[5:0];
                    dec_next.ss = request.second_value[5:0];
                end
                else
                begin
                    dec_next.rejected = 1'b1;
                end
            end
            tdc_pkg::ACT_LOAD_SEC:
            begin
                dec_next.op = tdc_pkg::OP_LOAD;
                if (pos_amt)
                begin
                    dec_next.use_div = 1'b1;
                end
                else
                begin
                    dec_next.rejected = 1'b1;
                end
            end
            default:
            begin
                dec_next.op = tdc_pkg::OP_KEEP;
            end
        endcase
    end

    // ---- seconds split datapath ----
    // stage 1: (amount >> 7) * reciprocal of 675
    assign hi_next = request.amount[30:tdc_pkg::LO_BITS];
    assign p1_next = 49'(hi_next) * 49'(tdc_pkg::RECIP_DAY_HI);

    // stage 2: remainder mod 675, rejoin low bits -> amount mod 86400
    assign q1      = 15'(p1_reg >> tdc_pkg::SHIFT_DAY_HI);
    assign r1      = hi_reg - 24'(q1) * 24'(tdc_pkg::DAY_HI_DIV);
    assign t2_next = {r1[9:0], lo1_reg};

    // stage 3: t * reciprocal of 3600
    assign p3_next = 35'(t2_reg) * 35'(tdc_pkg::RECIP_HOUR);

    // stage 4: hour and seconds within hour
    assign h4_next   = 5'(p3_reg >> tdc_pkg::SHIFT_HOUR);
    assign rem4_full = t3_reg - 17'(h4_next) * 17'(tdc_pkg::HOUR_SECONDS);
    assign rem4_next = rem4_full[11:0];

    // stage 5: rem * reciprocal of 60
    assign p5_next = 25'(rem4_reg) * 25'(tdc_pkg::RECIP_MINUTE);

    // output: minute and second
    assign m_fin  = 6'(p5_reg >> tdc_pkg::SHIFT_MINUTE);
    assign s_full = rem5_reg - 12'(m_fin) * 12'(tdc_pkg::MINUTE_SECONDS);

    assign vld_next = {vld_reg[tdc_pkg::FRONT_STAGES-2:0], push};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg[0] <= dec_next;
            for (int i = 1; i < tdc_pkg::FRONT_STAGES; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
            hi_reg   <= hi_next;
            p1_reg   <= p1_next;
            lo1_reg  <= request.amount[tdc_pkg::LO_BITS-1:0];
            t2_reg   <= t2_next;
            p3_reg   <= p3_next;
            t3_reg   <= t2_reg;
            h4_reg   <= h4_next;
            rem4_reg <= rem4_next;
            p5_reg   <= p5_next;
            rem5_reg <= rem4_reg;
            h5_reg   <= h4_reg;
        end
    end

    always_comb
    begin
        cmd.op       = pipe_reg[tdc_pkg::FRONT_STAGES-1].op;
        cmd.rejected = pipe_reg[tdc_pkg::FRONT_STAGES-1].rejected;
        if (pipe_reg[tdc_pkg::FRONT_STAGES-1].use_div)
        begin
            cmd.hh = h5_reg;
            cmd.mm = m_fin;
            cmd.ss = s_full[5:0];
        end
        else
        begin
            cmd.hh = pipe_reg[tdc_pkg::FRONT_STAGES-1].hh;
            cmd.mm = pipe_reg[tdc_pkg::FRONT_STAGES-1].mm;
            cmd.ss = pipe_reg[tdc_pkg::FRONT_STAGES-1].ss;
        end
    end

    assign cmd_valid = vld_reg[tdc_pkg::FRONT_STAGES-1];

endmodule

// ----- rtl/core/tdc_queue.sv -----
// ---------------------------------------------------------------------------
// tdc_queue
// Small FIFO of decoded commands between front and back.
// ---------------------------------------------------------------------------
module tdc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  tdc_pkg::cmd_t    wr_data,
    input  logic             rd,
    output tdc_pkg::cmd_t    rd_data,
    output tdc_pkg::q_stat_t stat
);

    tdc_pkg::cmd_t                     mem_reg [tdc_pkg::QUEUE_DEPTH];
    logic [tdc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [tdc_pkg::QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [tdc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [tdc_pkg::QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [tdc_pkg::QUEUE_CNT_W-1:0]   cnt_reg;
    logic [tdc_pkg::QUEUE_CNT_W-1:0]   cnt_next;
    logic                              do_wr;
    logic                              do_rd;

    assign stat.full  = (cnt_reg == tdc_pkg::QUEUE_CNT_W'(tdc_pkg::QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign stat.count = cnt_reg;

    assign do_wr = wr && !stat.full;
    assign do_rd = rd && !stat.empty;

    assign wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];

endmodule

// ----- rtl/core/tdc_back.sv -----
// ---------------------------------------------------------------------------
// tdc_back
// Holds the time, applies commands, registers one result item.
// ---------------------------------------------------------------------------
module tdc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  tdc_pkg::cmd_t      cmd,
    output logic               take,
    input  logic               pop,
    output logic               empty,
    output tdc_pkg::out_item_t response
);

    logic [4:0]         hours_reg;
    logic [4:0]         hours_next;
    logic [5:0]         minutes_reg;
    logic [5:0]         minutes_next;
    logic [5:0]         seconds_reg;
    logic [5:0]         seconds_next;
    logic               out_vld_reg;
    logic               out_vld_next;
    tdc_pkg::out_item_t out_reg;

    logic [6:0]         s_sum;
    logic [6:0]         m_sum;
    logic [5:0]         h_sum;
    logic               s_carry;
    logic               m_carry;
    logic [5:0]         s_add;
    logic [5:0]         m_add;
    logic [4:0]         h_add;

    assign take = cmd_valid && (!out_vld_reg || pop);

    // mixed-radix add of h:m:s delta, wraps at 24 h
    assign s_sum   = 7'(seconds_reg) + 7'(cmd.ss);
    assign s_carry = (s_sum >= 7'(tdc_pkg::MINUTE_SECONDS));
    assign s_add   = s_carry ? 6'(s_sum - 7'(tdc_pkg::MINUTE_SECONDS)) : s_sum[5:0];
    assign m_sum   = 7'(minutes_reg) + 7'(cmd.mm) + 7'(s_carry);
    assign m_carry = (m_sum >= 7'(tdc_pkg::MINUTE_SECONDS));
    assign m_add   = m_carry ? 6'(m_sum - 7'(tdc_pkg::MINUTE_SECONDS)) : m_sum[5:0];
    assign h_sum   = 6'(hours_reg) + 6'(cmd.hh) + 6'(m_carry);
    assign h_add   = (h_sum >= 6'(tdc_pkg::HOURS_PER_DAY))
                     ? 5'(h_sum - 6'(tdc_pkg::HOURS_PER_DAY)) : h_sum[4:0];

    always_comb
    begin
        hours_next   = hours_reg;
        minutes_next = minutes_reg;
        seconds_next = seconds_reg;
        if (take)
        begin
            case (cmd.op)
                tdc_pkg::OP_ADD:
                begin
                    hours_next   = h_add;
                    minutes_next = m_add;
                    seconds_next = s_add;
                end
                tdc_pkg::OP_SET_H: hours_next   = cmd.hh;
                tdc_pkg::OP_SET_M: minutes_next = cmd.mm;
                tdc_pkg::OP_SET_S: seconds_next = cmd.ss;
                tdc_pkg::OP_LOAD:
                begin
                    hours_next   = cmd.hh;
                    minutes_next = cmd.mm;
                    seconds_next = cmd.ss;
                end
                default:
                begin
                    hours_next = hours_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (take)
        begin
            out_vld_next = 1'b1;
        end
        else if (pop)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hours_reg   <= '0;
            minutes_reg <= '0;
            seconds_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            hours_reg   <= hours_next;
            minutes_reg <= minutes_next;
            seconds_reg <= seconds_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg.hour_now   <= hours_next;
            out_reg.minute_now <= minutes_next;
            out_reg.second_now <= seconds_next;
            out_reg.rejected   <= cmd.rejected;
        end
    end

    assign empty    = !out_vld_reg;
    assign response = out_reg;

endmodule

// ----- rtl/core/time_of_day_seconds_counter.sv -----
// An accepted item flows through the front pipeline, queue and result register.
// Throughput: one item per cycle; the result register and the command queue
// let input and output stall independently.
// The front pipeline (5 stages, one constant multiply each) sets the latency.
// Reset: time 00:00:00, pipeline, queue and result register emptied at once.
// ---------------------------------------------------------------------------
// time_of_day_seconds_counter
// 24-hour h:m:s counter driven by tick, add, set and load items.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module time_of_day_seconds_counter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  tdc_pkg::in_item_t  request,
    output logic               empty,
    input  logic               pop,
    output tdc_pkg::out_item_t response
);

    // Front: decodes the action. Add and load-seconds amounts are reduced
    // mod 86400 and split into h:m:s through exact reciprocal multiplies,
    // so every command reaching the back is a field write, a full load, an h:m:s
    // delta or a no-op for a refused add/set. Ticks become +00:00:01 or +23:59:59.
    logic             f_cmd_valid;
    tdc_pkg::cmd_t    f_cmd;

    // Queue: decouples the front pipeline from the back.
    tdc_pkg::cmd_t    q_cmd;
    tdc_pkg::q_stat_t q_stat;
    logic             q_pop;

    // result fields all inside a legal time of day
    logic             res_in_range;

    tdc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .cmd_valid (f_cmd_valid),
        .cmd       (f_cmd),
        .q_full    (q_stat.full)
    );

    tdc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_cmd_valid),
        .wr_data (f_cmd),
        .rd      (q_pop),
        .rd_data (q_cmd),
        .stat    (q_stat)
    );

    // Back: owns the time registers; one mixed-radix add per cycle unless output stalls.
    tdc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_stat.empty),
        .cmd       (q_cmd),
        .take      (q_pop),
        .pop       (pop),
        .empty     (empty),
        .response  (response)
    );

    // ---- checks ----
    assign res_in_range = (response.hour_now <= 5'(tdc_pkg::MAX_HOUR))
                          && (response.minute_now <= 6'(tdc_pkg::MAX_MINUTE))
                          && (response.second_now <= 6'(tdc_pkg::MAX_MINUTE));

    `ASSERT_IMPLIES(a_result_range, clk, rst_n, !empty, res_in_range, "result time out of range")
    `ASSERT_IMPLIES(a_full_only_on_queue, clk, rst_n, full, q_stat.full, "input stalled with room")
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, full && !q_pop, full, "stall released without read")
    `ASSERT_IMPLIES(a_queue_bound, clk, rst_n, 1'b1, q_stat.count <= 3'(tdc_pkg::QUEUE_DEPTH), "queue count overflow")

endmodule

// ----- verif/tb_time_of_day_seconds_counter.sv -----
// ----------------------------------------------------------------------------
// tb_time_of_day_seconds_counter
// Self-checking bench for the 24-hour time-of-day counter. A directed set of
// wrap, range and overflow items runs first, then a long random mix. Each
// item's expected h:m:s and reject flag is computed in the bench when the item
// is taken, and compared against the result port in arrival order. Both
// sides see random idle bursts.
// ----------------------------------------------------------------------------
module tb_time_of_day_seconds_counter;

    timeunit 1ns;
    timeprecision 1ps;

    import tdc_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    // no idling once this few items are left to send
    localparam int QUIET_TAIL   = 150;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    in_item_t  request = '0;
    logic      full;
    logic      empty;
    out_item_t response;

    // items waiting to go in, and the times they must produce
    in_item_t  actions_to_send[$];
    out_item_t expected_times[$];

    // bench copy of the clock state
    logic [4:0] now_hour   = '0;
    logic [5:0] now_minute = '0;
    logic [5:0] now_second = '0;

    int error_count   = 0;
    int send_gap      = 0;
    int take_gap      = 0;
    int send_idle_pct = 10;
    int take_idle_pct = 10;

    time_of_day_seconds_counter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .request  (request),
        .empty    (empty),
        .pop      (pop),
        .response (response)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench model of the counter
    // ------------------------------------------------------------------------

    // Break a second count into h:m:s, wrapping at one day.
    function automatic void split_seconds(longint total);
        longint t;
        t          = total % DAY_SECONDS;
        now_hour   = 5'(t / HOUR_SECONDS);
        now_minute = 6'((t % HOUR_SECONDS) / MINUTE_SECONDS);
        now_second = 6'(t % MINUTE_SECONDS);
    endfunction

    // Apply one item to the bench state and return the time it should report.
    function automatic out_item_t apply_action(in_item_t req);
        longint    total;
        longint    amt;
        int        hv;
        int        mv;
        int        sv;
        bit        hour_ok;
        bit        minute_ok;
        bit        second_ok;
        bit        refused;
        out_item_t res;
        total     = longint'(now_hour) * HOUR_SECONDS + longint'(now_minute) * MINUTE_SECONDS
                    + longint'(now_second);
        amt       = req.amount;         // sign-extended
        hv        = req.hour_value;
        mv        = req.minute_value;
        sv        = req.second_value;
        hour_ok   = (hv >= 0) && (hv <= MAX_HOUR);
        minute_ok = (mv >= 0) && (mv <= MAX_MINUTE);
        second_ok = (sv >= 0) && (sv <= MAX_MINUTE);
        refused   = 1'b0;
        case (action_t'(req.action))
            ACT_TICK_UP:   split_seconds(total + 1);
            ACT_TICK_DOWN: split_seconds(total + DAY_SECONDS - 1);
            ACT_ADD:
                if (amt > 0) split_seconds(total + amt);
                else         refused = 1'b1;
            ACT_SET_HOUR:
                if (hour_ok) now_hour = 5'(hv);
                else         refused = 1'b1;
            ACT_SET_MIN:
                if (minute_ok) now_minute = 6'(mv);
                else           refused = 1'b1;
            ACT_SET_SEC:
                if (second_ok) now_second = 6'(sv);
                else           refused = 1'b1;
            ACT_LOAD_HMS:
                if (hour_ok && minute_ok && second_ok)
                begin
                    now_hour   = 5'(hv);
                    now_minute = 6'(mv);
                    now_second = 6'(sv);
                end
                else
                begin
                    split_seconds(0);       // any bad field clears the clock
                    refused = 1'b1;
                end
            default:                        // load seconds
                if (amt > 0)
                begin
                    split_seconds(amt);
                end
                else
                begin
                    split_seconds(0);
                    refused = 1'b1;
                end
        endcase
        res.hour_now   = now_hour;
        res.minute_now = now_minute;
        res.second_now = now_second;
        res.rejected   = refused;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic in_item_t make_item(action_t act, logic signed [31:0] amt,
                                           logic signed [7:0] h, logic signed [7:0] m,
                                           logic signed [7:0] s);
        in_item_t it;
        it.action       = act;
        it.amount       = amt;
        it.hour_value   = h;
        it.minute_value = m;
        it.second_value = s;
        return it;
    endfunction

    // Mostly legal field values, leaning on the edges of the range.
    function automatic logic signed [7:0] rand_field(int max_ok);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 8'($urandom_range(0, max_ok));
            6:                return 8'(max_ok - $urandom_range(0, 1));
            7:                return 8'($urandom_range(max_ok + 1, 127));
            8:                return 8'(-$urandom_range(1, 128));
            default:          return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Fraction of cycles that open an idle burst; zero gives calm stretches.
    function automatic int pick_idle_pct();
        case ($urandom_range(0, 4))
            0, 1:    return 0;
            2:       return 5;
            3:       return 15;
            default: return 40;
        endcase
    endfunction

    task automatic compare_field(string name, int exp_val, int got_val);
        if (exp_val != got_val)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, got_val);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers the head of actions_to_send; the expected time is
    // computed on the edge where the item is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
                expected_times.push_back(apply_action(actions_to_send.pop_front()));

            if ($urandom_range(0, 199) == 0)
                send_idle_pct = pick_idle_pct();

            if (push && full)
            begin
                // stalled: hold the item
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (actions_to_send.size() == 0)
            begin
                push <= 1'b0;
            end
            else if (actions_to_send.size() > QUIET_TAIL &&
                     $urandom_range(0, 99) < send_idle_pct)
            begin
                send_gap = $urandom_range(1, 11) - 1;   // the current idle cycle is part of the gap
                push <= 1'b0;
            end
            else
            begin
                push    <= 1'b1;
                request <= actions_to_send[0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes results and checks them against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_times.size() == 0)
                begin
                    $display("%0t ns: result with none expected, actual %0d:%0d:%0d rej %0d",
                             $time, response.hour_now, response.minute_now,
                             response.second_now, response.rejected);
                    error_count++;
                end
                else
                begin
                    out_item_t want;
                    want = expected_times.pop_front();
                    compare_field("hour_now",   want.hour_now,   response.hour_now);
                    compare_field("minute_now", want.minute_now, response.minute_now);
                    compare_field("second_now", want.second_now, response.second_now);
                    compare_field("rejected",   want.rejected,   response.rejected);
                end
            end

            if ($urandom_range(0, 199) == 0)
                take_idle_pct = pick_idle_pct();

            if (take_gap > 0)
            begin
                take_gap--;
                pop <= 1'b0;
            end
            else if (actions_to_send.size() > QUIET_TAIL &&
                     $urandom_range(0, 99) < take_idle_pct)
            begin
                take_gap = $urandom_range(1, 11) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int                 n;
        int                 r;
        action_t            act;
        logic signed [31:0] amt;

        // Directed: wraps both ways, add/load edges, set range limits.
        actions_to_send.push_back(make_item(ACT_TICK_UP,   0, 0, 0, 0));
        actions_to_send.push_back(make_item(ACT_TICK_DOWN, 0, 0, 0, 0));
        actions_to_send.push_back(make_item(ACT_TICK_DOWN, 0, 0, 0, 0));  // to 23:59:59
        actions_to_send.push_back(make_item(ACT_TICK_UP,   0, 0, 0, 0));  // back to midnight
        actions_to_send.push_back(make_item(ACT_ADD, 0, 0, 0, 0));        // zero: refused
        actions_to_send.push_back(make_item(ACT_ADD, -1, 0, 0, 0));
        actions_to_send.push_back(make_item(ACT_ADD, 32'sh8000_0000, -1, -1, -1));
        actions_to_send.push_back(make_item(ACT_ADD, 32'sh7fff_ffff, 0, 0, 0));
        actions_to_send.push_back(make_item(ACT_ADD, 1, 0, 0, 0));
        actions_to_send.push_back(make_item(ACT_SET_HOUR, 0, 23, 0, 0));
        actions_to_send.push_back(make_item(ACT_SET_HOUR, 0, 24, 0, 0));
        actions_to_send.push_back(make_item(ACT_SET_HOUR, 0, -1, 0, 0));
        actions_to_send.push_back(make_item(ACT_SET_HOUR, 0, 127, 0, 0));
        actions_to_send.push_back(make_item(ACT_SET_MIN, 0, 0, 59, 0));
        actions_to_send.push_back(make_item(ACT_SET_MIN, 0, 0, 60, 0));
        actions_to_send.push_back(make_item(ACT_SET_MIN, 0, 0, -128, 0));
        actions_to_send.push_back(make_item(ACT_SET_SEC, 0, 0, 0, 59));
        actions_to_send.push_back(make_item(ACT_SET_SEC, 0, 0, 0, 60));
        actions_to_send.push_back(make_item(ACT_TICK_UP, 0, 0, 0, 0));    // wrap from 23:59:59
        actions_to_send.push_back(make_item(ACT_LOAD_HMS, 0, 23, 59, 59));
        actions_to_send.push_back(make_item(ACT_LOAD_HMS, 0, 24, 0, 0));  // bad hour clears
        actions_to_send.push_back(make_item(ACT_LOAD_HMS, 0, 12, 30, -1));
        actions_to_send.push_back(make_item(ACT_LOAD_SEC, 0, 0, 0, 0));
        actions_to_send.push_back(make_item(ACT_LOAD_SEC, 32'sh8000_0000, 0, 0, 0));
        actions_to_send.push_back(make_item(ACT_LOAD_SEC, DAY_SECONDS - 1, 0, 0, 0));
        actions_to_send.push_back(make_item(ACT_LOAD_SEC, DAY_SECONDS, 0, 0, 0));
        actions_to_send.push_back(make_item(ACT_LOAD_SEC, 32'sh7fff_ffff, 0, 0, 0));

        // Random mix; ticks weighted up so they cross the wrap points often.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = $urandom_range(0, 11);
            if (r >= 8)
                act = (r % 2) ? ACT_TICK_DOWN : ACT_TICK_UP;
            else
                act = action_t'(r);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: amt = $urandom_range(1, 200000);
                4:          amt = $urandom;
                5:          amt = $urandom_range(0, 6) - 3;
                6:          amt = DAY_SECONDS * $urandom_range(0, 24000)
                                  + $urandom_range(0, 2) - 1;
                7:
                    case ($urandom_range(0, 3))
                        0:       amt = 32'sh7fff_ffff;
                        1:       amt = 32'sh8000_0000;
                        2:       amt = 32'sh8000_0001;
                        default: amt = -1;
                    endcase
                8:          amt = -$urandom_range(1, 100000);
                default:    amt = $urandom_range(1, 100);
            endcase
            actions_to_send.push_back(make_item(act, amt, rand_field(MAX_HOUR),
                                                rand_field(MAX_MINUTE),
                                                rand_field(MAX_MINUTE)));
        end

        repeat (10) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (actions_to_send.size() != 0 || expected_times.size() != 0)
            @(negedge clk);
        // let any stray result show up
        repeat (20) @(negedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/tdc_pkg.sv
rtl/core/tdc_front.sv
rtl/core/tdc_queue.sv
rtl/core/tdc_back.sv
rtl/core/time_of_day_seconds_counter.sv
verif/tb_time_of_day_seconds_counter.sv
